FILE: hdl/dvl_pkg.sv
// Shared constants, types and result fields for the distinct value labeler.
package dvl_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_DISTINCT_DEF = 64;
   localparam int KEY_BITS_DEF     = 32;

   // Fixed field widths of the streams
   localparam int SAMPLE_BITS   = 32;
   localparam int LABEL_BITS    = 6;
   localparam int COUNT_BITS    = 7;
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 16;
   localparam int RSP_USER_BITS = 2;

   // Scan sequencer states
   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_RUN,
      SCAN_DONE
   } scan_state_type;

   // One labelled result word
   typedef struct packed {
      logic [LABEL_BITS-1:0] label;
      logic                  first_seen;
      logic                  overflow;
      logic [COUNT_BITS-1:0] distinct_count;
      logic                  final_result;
   } result_type;

endpackage

FILE: hdl/dvl_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module dvl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/dvl_scan.sv
// Dictionary scan sequencer: searches the stored keys and appends new ones.
module dvl_scan #(
   parameter int MAX_DISTINCT = dvl_pkg::MAX_DISTINCT_DEF,
   parameter int KEY_BITS     = dvl_pkg::KEY_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [dvl_pkg::SAMPLE_BITS-1:0]    req_key,
   input  logic                               req_last,
   output logic                               res_valid,
   input  logic                               res_ready,
   output dvl_pkg::result_type                res
);

   import dvl_pkg::*;

   localparam int CMP_BITS = (KEY_BITS < SAMPLE_BITS) ? KEY_BITS : SAMPLE_BITS;
   localparam int IW       = $clog2(MAX_DISTINCT);
   localparam int CW       = $clog2(MAX_DISTINCT + 1);
   localparam logic [CW-1:0] MaxCount = CW'(MAX_DISTINCT);

   scan_state_type    state_ff, state_in;
   logic [CMP_BITS-1:0] key_ff, key_in;
   logic              last_ff, last_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     iss_ff, iss_in;
   logic              pend_ff, pend_in;
   logic [IW-1:0]     cmp_idx_ff, cmp_idx_in;
   logic              found_ff, found_in;
   logic [IW-1:0]     hit_ff, hit_in;

   logic                ram_rd_en;
   logic [CMP_BITS-1:0] ram_rd_data;
   logic                ram_wr_en;
   logic                full;
   logic [CW-1:0]       new_count;

   // Dictionary store
   dvl_ram #(
      .WIDTH (CMP_BITS),
      .DEPTH (MAX_DISTINCT)
   ) u_dict (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (key_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (iss_ff[IW-1:0]),
      .rd_data (ram_rd_data)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      last_ff    <= last_in;
      iss_ff     <= iss_in;
      cmp_idx_ff <= cmp_idx_in;
      found_ff   <= found_in;
      hit_ff     <= hit_in;
   end

   // Outcome of the finished search
   assign full      = (count_ff == MaxCount);
   assign new_count = (found_ff || full) ? count_ff : count_ff + 1'b1;

   // Next state and outputs
   always_comb begin
      state_in   = state_ff;
      key_in     = key_ff;
      last_in    = last_ff;
      count_in   = count_ff;
      iss_in     = iss_ff;
      pend_in    = pend_ff;
      cmp_idx_in = cmp_idx_ff;
      found_in   = found_ff;
      hit_in     = hit_ff;
      ram_rd_en  = 1'b0;
      ram_wr_en  = 1'b0;
      req_ready  = 1'b0;
      res_valid  = 1'b0;

      res.label          = found_ff ? LABEL_BITS'(hit_ff)
                         : (full ? '0 : LABEL_BITS'(count_ff[IW-1:0]));
      res.first_seen     = !found_ff && !full;
      res.overflow       = !found_ff && full;
      res.distinct_count = last_ff ? COUNT_BITS'(new_count) : '0;
      res.final_result   = last_ff;

      case (state_ff)
         SCAN_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in   = req_key[CMP_BITS-1:0];
               last_in  = req_last;
               iss_in   = '0;
               pend_in  = 1'b0;
               found_in = 1'b0;
               state_in = (count_ff == '0) ? SCAN_DONE : SCAN_RUN;
            end
         end
         SCAN_RUN: begin
            // issue one read a cycle over the valid entries
            if (iss_ff != count_ff) begin
               ram_rd_en  = 1'b1;
               iss_in     = iss_ff + 1'b1;
               pend_in    = 1'b1;
               cmp_idx_in = iss_ff[IW-1:0];
            end else begin
               pend_in = 1'b0;
            end
            // compare the word read last cycle; stop at the first match
            if (pend_ff && (ram_rd_data == key_ff)) begin
               found_in = 1'b1;
               hit_in   = cmp_idx_ff;
               pend_in  = 1'b0;
               state_in = SCAN_DONE;
            end else if (pend_ff && (iss_ff == count_ff)) begin
               pend_in  = 1'b0;
               state_in = SCAN_DONE;
            end
         end
         SCAN_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               ram_wr_en = !found_ff && !full;
               count_in  = last_ff ? '0 : new_count;
               state_in  = SCAN_IDLE;
            end
         end
         default: begin
            state_in = SCAN_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/distinct_value_labeler.sv
// Each accepted word is compared with the dictionary entries in order, from 1 to MAX_DISTINCT
// of them, stopping at the first match; with an empty dictionary none are compared. The
// dictionary RAM read port is scanned one entry a cycle, and the next word is taken the cycle
// after its result is loaded, so a new word waits until the last one is through. An output
// register holds a result while a new word enters.
// Reset clears the entry count, sequencer and output valid; the RAM is not cleared.
module distinct_value_labeler #(
   parameter int MAX_DISTINCT = dvl_pkg::MAX_DISTINCT_DEF,
   parameter int KEY_BITS     = dvl_pkg::KEY_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dvl_pkg::REQ_DATA_BITS-1:0] req_tdata,  // [31:0] sample_key
   input  logic                              req_tlast,  // end_of_field
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dvl_pkg::RSP_DATA_BITS-1:0] rsp_tdata,  // [5:0] label, [12:6] distinct_count
   output logic [dvl_pkg::RSP_USER_BITS-1:0] rsp_tuser,  // [0] first_seen, [1] overflow
   output logic                              rsp_tlast   // final_result
);

   import dvl_pkg::*;

   logic       res_valid;
   logic       res_ready;
   result_type res;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   // Search engine with the dictionary store
   dvl_scan #(
      .MAX_DISTINCT (MAX_DISTINCT),
      .KEY_BITS     (KEY_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_key   (req_tdata[SAMPLE_BITS-1:0]),
      .req_last  (req_tlast),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // Load the output register when it is empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Pack the result word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - LABEL_BITS - COUNT_BITS){1'b0}},
                        rsp_ff.distinct_count, rsp_ff.label};
   assign rsp_tuser  = {rsp_ff.overflow, rsp_ff.first_seen};
   assign rsp_tlast  = rsp_ff.final_result;

endmodule

FILE: tb/tb_distinct_value_labeler.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the distinct value labeler.
module tb_distinct_value_labeler;
   import dvl_pkg::*;

   localparam int MAX_DISTINCT = MAX_DISTINCT_DEF;
   localparam int KEY_BITS     = KEY_BITS_DEF;
   localparam logic [SAMPLE_BITS-1:0] KEY_MASK = (KEY_BITS >= SAMPLE_BITS) ? '1 :
      ({SAMPLE_BITS{1'b1}} >> (SAMPLE_BITS - KEY_BITS));
   localparam int SAMPLE_TARGET = 1600;
   localparam int MAX_WAIT      = 16;
   localparam int IDLE_LIMIT    = 4000;

   typedef struct {
      logic [SAMPLE_BITS-1:0] key;
      logic                   last;
      bit                     drain;
      int unsigned            gap;
   } sample_item_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;  // [31:0] sample_key
   logic                     req_tlast  = 1'b0;  // end_of_field
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;  // [5:0] label, [12:6] distinct_count
   logic [RSP_USER_BITS-1:0] rsp_tuser;  // [0] first_seen, [1] overflow
   logic                     rsp_tlast;  // final_result

   // Dictionary mirror and stores of pending words
   logic [SAMPLE_BITS-1:0] dict_keys [MAX_DISTINCT];
   int unsigned            dict_fill = 0;
   sample_item_type        sample_queue [$];
   result_type             label_queue [$];
   int unsigned            samples_queued = 0;
   int unsigned            mismatch_count = 0;
   bit                     sender_calm    = 1'b0;

   distinct_value_labeler #(
      .MAX_DISTINCT(MAX_DISTINCT),
      .KEY_BITS    (KEY_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always #2 clock = ~clock;

   // Look the sample up, append it if new, and close the field on the last word
   function automatic result_type label_sample(logic [SAMPLE_BITS-1:0] sample, logic last);
      result_type             r;
      logic [SAMPLE_BITS-1:0] key;
      bit                     hit;
      key = sample & KEY_MASK;
      r   = '0;
      hit = 1'b0;
      for (int i = 0; i < dict_fill; i++) begin
         if (!hit && dict_keys[i] == key) begin
            hit     = 1'b1;
            r.label = LABEL_BITS'(i);
         end
      end
      if (!hit) begin
         if (dict_fill < MAX_DISTINCT) begin
            dict_keys[dict_fill] = key;
            r.label      = LABEL_BITS'(dict_fill);
            r.first_seen = 1'b1;
            dict_fill++;
         end else begin
            r.overflow = 1'b1;
         end
      end
      if (last) begin
         r.distinct_count = COUNT_BITS'(dict_fill);
         dict_fill        = 0;
      end
      r.final_result = last;
      return r;
   endfunction

   function automatic void queue_sample(logic [SAMPLE_BITS-1:0] key, logic last,
                                        bit drain = 1'b0);
      sample_item_type s;
      s.key   = key;
      s.last  = last;
      s.drain = drain;
      s.gap   = sender_calm ? 0 : $urandom_range(0, MAX_WAIT);
      sample_queue.insert(sample_queue.size(), s);
      samples_queued++;
   endfunction

   // Build a field from a pool of values, some of them one bit apart
   function automatic void queue_field(int unsigned pool_size, int unsigned length,
                                       bit sweep, bit drain);
      logic [SAMPLE_BITS-1:0] pool [$];
      logic [SAMPLE_BITS-1:0] k;
      for (int i = 0; i < pool_size; i++) begin
         if (i > 0 && $urandom_range(0, 3) == 0)
            k = pool[$urandom_range(0, i - 1)] ^ (32'd1 << $urandom_range(0, 31));
         else
            k = $urandom;
         pool.insert(pool.size(), k);
      end
      for (int j = 0; j < length; j++) begin
         if (sweep && j < pool_size)
            k = pool[j];
         else if ($urandom_range(0, 3) == 0)
            k = $urandom;
         else
            k = pool[$urandom_range(0, pool_size - 1)];
         queue_sample(k, j == length - 1, drain && j == 0);
      end
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Driver: present queued samples after their gap, hold until taken
   sample_item_type drv_item;
   bit              drv_loaded = 1'b0;
   int unsigned     drv_gap    = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         drv_loaded = 1'b0;
      end else begin
         // predict the word taken at this edge
         if (req_tvalid && req_tready) begin
            label_queue.insert(label_queue.size(), label_sample(req_tdata, req_tlast));
            drv_loaded = 1'b0;
         end
         if (!drv_loaded && sample_queue.size() != 0) begin
            drv_item   = sample_queue.pop_front();
            drv_loaded = 1'b1;
            drv_gap    = drv_item.gap;
         end
         if (req_tvalid && !req_tready) begin
            // hold the word on the bus
         end else if (drv_loaded && drv_gap != 0) begin
            drv_gap--;
            req_tvalid <= 1'b0;
         end else if (drv_loaded && (!drv_item.drain || label_queue.size() == 0)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= drv_item.key;
            req_tlast  <= drv_item.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: take result words, compare with the oldest prediction, then stall
   result_type  mon_expect;
   int unsigned mon_stall     = 0;
   int unsigned mon_words     = 0;
   bit          receiver_calm = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         mon_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (label_queue.size() == 0) begin
               $display({"%0t ns: unexpected result word, expected none, ",
                         "actual tdata=%h tuser=%b tlast=%b"},
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               mismatch_count++;
            end else begin
               mon_expect = label_queue.pop_front();
               check_field("label", 32'(mon_expect.label), 32'(rsp_tdata[5:0]));
               check_field("distinct_count", 32'(mon_expect.distinct_count),
                           32'(rsp_tdata[12:6]));
               check_field("tdata padding", 0, 32'(rsp_tdata[RSP_DATA_BITS-1:13]));
               check_field("first_seen", 32'(mon_expect.first_seen), 32'(rsp_tuser[0]));
               check_field("overflow", 32'(mon_expect.overflow), 32'(rsp_tuser[1]));
               check_field("final_result", 32'(mon_expect.final_result), 32'(rsp_tlast));
            end
            mon_words++;
            if (mon_words % 128 == 0)
               receiver_calm = ($urandom_range(0, 3) == 0);
            mon_stall = receiver_calm ? 0 : $urandom_range(0, MAX_WAIT);
         end
         if (mon_stall != 0) begin
            mon_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: count cycles with no word moving on either side
   int unsigned idle_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("distinct_value_labeler verification failed");
            $finish;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      logic [SAMPLE_BITS-1:0] tagged_keys [MAX_DISTINCT];
      logic [SAMPLE_BITS-1:0] k;
      int unsigned            r;

      // directed: key extremes, repeats, one-word field, neighbours, new value as last
      queue_sample(32'h0000_0000, 1'b0);
      queue_sample(32'hFFFF_FFFF, 1'b0);
      queue_sample(32'h0000_0000, 1'b0);
      queue_sample(32'hFFFF_FFFF, 1'b1);
      queue_sample(32'h8000_0000, 1'b1);
      queue_sample(32'h0000_0001, 1'b0);
      queue_sample(32'h0000_0003, 1'b0);
      queue_sample(32'h0000_0001, 1'b1);
      queue_sample(32'h5A5A_5A5A, 1'b0);
      queue_sample(32'hA5A5_A5A5, 1'b1);
      queue_sample(32'hDEAD_BEEF, 1'b0);
      queue_sample(32'hDEAD_BEEF, 1'b0);
      queue_sample(32'hDEAD_BEEF, 1'b1);

      // fill the dictionary exactly, closing on the 64th distinct value
      for (int i = 0; i < MAX_DISTINCT; i++) begin
         k = $urandom;
         tagged_keys[i] = {k[SAMPLE_BITS-1:6], 6'(i)};
         queue_sample(tagged_keys[i], i == MAX_DISTINCT - 1, i == 0);
      end
      // fill again, then a repeat, an overflow, another repeat and an overflow as the last word
      for (int i = 0; i < MAX_DISTINCT; i++)
         queue_sample(tagged_keys[i], 1'b0, i == 0);
      queue_sample(tagged_keys[3], 1'b0);
      queue_sample(tagged_keys[5] ^ 32'h8000_0000, 1'b0);
      queue_sample(tagged_keys[9], 1'b0);
      queue_sample(tagged_keys[7] ^ 32'h4000_0000, 1'b1);

      // random fields, mostly well formed, some past the dictionary size, some noise
      while (samples_queued < SAMPLE_TARGET) begin
         sender_calm = ($urandom_range(0, 4) == 0);
         r = $urandom_range(0, 9);
         if (r == 0) begin
            repeat ($urandom_range(1, 8))
               queue_sample($urandom, $urandom_range(0, 3) == 0);
         end else if (r == 1) begin
            queue_field($urandom_range(50, 90), $urandom_range(60, 140),
                        $urandom_range(0, 1) == 1, $urandom_range(0, 5) == 0);
         end else begin
            queue_field($urandom_range(1, 16), $urandom_range(1, 40), 1'b0,
                        $urandom_range(0, 30) == 0);
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (sample_queue.size() != 0 || drv_loaded) @(posedge clock);
      while (label_queue.size() != 0) @(posedge clock);
      repeat (2 * MAX_DISTINCT + 8) @(posedge clock);

      if (mismatch_count == 0)
         $display("distinct_value_labeler verification clean");
      else
         $display("distinct_value_labeler verification failed");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/dvl_pkg.sv
hdl/dvl_ram.sv
hdl/dvl_scan.sv
hdl/distinct_value_labeler.sv
tb/tb_distinct_value_labeler.sv
